// ===== hw/rtl/swbd_pkg.sv =====
// Shared types and constants of the stopwatch with debounced buttons.
// Depends on nothing; the timer and the top level refer to it by scoped names.
`default_nettype none

package swbd_pkg;

	localparam logic [7:0] DEBOUNCE_RESET = 8'd4;
	localparam logic [6:0] HUNDREDTHS_LAST = 7'd99;
	localparam logic [5:0] SECONDS_LAST = 6'd59;
	localparam logic [5:0] MINUTES_LAST = 6'd59;

	// Control from the button logic to the time counters for one item.
	typedef struct packed {
		logic tick;
		logic toggle;
		logic clear;
	} swbd_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swbd_button.sv =====
// One debounced push button: arming flag and holdoff counter.
// Depends on no other file; the holdoff length comes in on debounce_ticks.
`default_nettype none

module swbd_button (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       update,
	input  wire logic       tick,
	input  wire logic       level,
	input  wire logic [7:0] debounce_ticks,
	output logic            press
);

	logic       armed_q;
	logic [7:0] holdoff_q;
	logic       armed_d;
	logic [7:0] holdoff_mid;
	logic [7:0] holdoff_d;

	// A press acts only when the button is armed and its holdoff has run out.
	assign press = update && !level && armed_q && (holdoff_q == 8'd0);

	always_comb begin
		armed_d = armed_q;
		holdoff_mid = holdoff_q;
		if (press) begin
			armed_d = 1'b0;
			holdoff_mid = debounce_ticks;
		end else if (!armed_q && level) begin
			armed_d = 1'b1;
		end
		holdoff_d = holdoff_mid;
		if (tick && (holdoff_mid != 8'd0)) begin
			holdoff_d = holdoff_mid - 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b1;
			holdoff_q <= 8'd0;
		end else if (update) begin
			armed_q <= armed_d;
			holdoff_q <= holdoff_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/swbd_timer.sv =====
// Run flag and cascaded hundredths, seconds, minutes and hours counters.
// Depends on swbd_pkg for the control struct and the counter limits.
`default_nettype none

module swbd_timer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                update,
	input  wire swbd_pkg::swbd_ctrl_t ctrl,
	output logic [7:0]               hours_q,
	output logic [5:0]               minutes_q,
	output logic [5:0]               seconds_q,
	output logic [6:0]               hundredths_q,
	output logic                     running_q
);

	logic       running_d;
	logic       step;
	logic       wrap_h;
	logic       wrap_s;
	logic       wrap_m;
	logic [7:0] hours_d;
	logic [5:0] minutes_d;
	logic [5:0] seconds_d;
	logic [6:0] hundredths_d;

	always_comb begin
		running_d = ctrl.clear ? 1'b0 : (running_q ^ ctrl.toggle);
		step = ctrl.tick && running_d && !ctrl.clear;
		wrap_h = hundredths_q == swbd_pkg::HUNDREDTHS_LAST;
		wrap_s = wrap_h && (seconds_q == swbd_pkg::SECONDS_LAST);
		wrap_m = wrap_s && (minutes_q == swbd_pkg::MINUTES_LAST);
		hundredths_d = hundredths_q;
		seconds_d = seconds_q;
		minutes_d = minutes_q;
		hours_d = hours_q;
		if (ctrl.clear) begin
			hundredths_d = 7'd0;
			seconds_d = 6'd0;
			minutes_d = 6'd0;
			hours_d = 8'd0;
		end else if (step) begin
			hundredths_d = wrap_h ? 7'd0 : hundredths_q + 7'd1;
			if (wrap_h) begin
				seconds_d = wrap_s ? 6'd0 : seconds_q + 6'd1;
			end
			if (wrap_s) begin
				minutes_d = wrap_m ? 6'd0 : minutes_q + 6'd1;
			end
			if (wrap_m) begin
				hours_d = hours_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hundredths_q <= 7'd0;
			seconds_q <= 6'd0;
			minutes_q <= 6'd0;
			hours_q <= 8'd0;
			running_q <= 1'b0;
		end else if (update) begin
			hundredths_q <= hundredths_d;
			seconds_q <= seconds_d;
			minutes_q <= minutes_d;
			hours_q <= hours_d;
			running_q <= running_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/stopwatch_with_button_debounce_top.sv =====
// Top level of the stopwatch with two debounced buttons.
// Depends on swbd_pkg, swbd_button and swbd_timer.
//
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall   tick, start_stop_pin, reset_pin
// out       source     out_valid / out_stall hours_count, minutes_count,
//                                             seconds_count, hundredths_count,
//                                             is_running
// cfg       sink       cfg_valid / cfg_ready cfg_data (holdoff length in ticks)
//
// Each item is taken into an input register and, when it advances, updates the
// button and time state, whose registers form the result. One item can be
// accepted every cycle while the output is not stalled. Reset clears the time,
// stops the watch, arms both buttons and sets the holdoff length to four ticks.
// While the result is stalled the input register still takes one more item and
// only then raises in_stall.
`default_nettype none

module stopwatch_with_button_debounce_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       tick,
	input  wire logic       start_stop_pin,
	input  wire logic       reset_pin,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      hours_count,
	output logic [5:0]      minutes_count,
	output logic [5:0]      seconds_count,
	output logic [6:0]      hundredths_count,
	output logic            is_running,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);

	logic                 valid_s1;
	logic                 tick_s1;
	logic                 ss_pin_s1;
	logic                 rst_pin_s1;
	logic                 out_valid_q;
	logic [7:0]           debounce_ticks_q;
	logic                 advance;
	logic                 ss_press;
	logic                 rst_press;
	swbd_pkg::swbd_ctrl_t ctrl;

	// The held item moves on when the result slot is empty or being taken.
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// The input payload needs no reset; it is only used when valid_s1 is set.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			tick_s1 <= tick;
			ss_pin_s1 <= start_stop_pin;
			rst_pin_s1 <= reset_pin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= swbd_pkg::DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			debounce_ticks_q <= cfg_data;
		end
	end

	// Start/stop button.
	swbd_button u_ss_button (
		.clk            (clk),
		.arst_n         (arst_n),
		.update         (advance),
		.tick           (tick_s1),
		.level          (ss_pin_s1),
		.debounce_ticks (debounce_ticks_q),
		.press          (ss_press)
	);

	// Reset button.
	swbd_button u_rst_button (
		.clk            (clk),
		.arst_n         (arst_n),
		.update         (advance),
		.tick           (tick_s1),
		.level          (rst_pin_s1),
		.debounce_ticks (debounce_ticks_q),
		.press          (rst_press)
	);

	assign ctrl.tick = tick_s1;
	assign ctrl.toggle = ss_press;
	assign ctrl.clear = rst_press;

	// The timer registers are the result register: they only change when an item
	// advances, which happens only when the result slot is empty or being taken.
	swbd_timer u_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (advance),
		.ctrl         (ctrl),
		.hours_q      (hours_count),
		.minutes_q    (minutes_count),
		.seconds_q    (seconds_count),
		.hundredths_q (hundredths_count),
		.running_q    (is_running)
	);

	// A reset press leaves a cleared, stopped watch in the result.
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rst_press |=> (hours_count == 8'd0) && (minutes_count == 6'd0) &&
			(seconds_count == 6'd0) && (hundredths_count == 7'd0) && !is_running)
		else $error("reset press did not clear the time");

	// The hundredths counter never leaves its range.
	a_hundredths_range: assert property (@(posedge clk) disable iff (!arst_n)
		hundredths_count <= swbd_pkg::HUNDREDTHS_LAST)
		else $error("hundredths counter out of range");

	// Stall is only raised while an item is held in the input register.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held item");

	// Without an advancing item the result state does not move.
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(hundredths_count) && $stable(is_running))
		else $error("result changed without an item");

endmodule

`default_nettype wire
